### rtl/core/lkv_pkg.sv
// ----------------------------------------------------------------------------
// lkv_pkg
// Shared types, constants and helpers of the look-at view matrix block.
// ----------------------------------------------------------------------------
package lkv_pkg;

  localparam int LKV_FRAC_BITS  = 16;
  localparam int LKV_ALIGN_W    = 30;  // normalized magnitude width
  localparam int LKV_SQRT_STEPS = 31;  // root bits of a 62-bit sum
  localparam int LKV_QDEPTH     = 2;

  localparam logic [1:0] LKV_COL_LAST = 2'd3;

  typedef struct packed {
    logic             degen;
    logic [2:0][31:0] s;
    logic [2:0][31:0] v;
    logic [2:0][31:0] nf;
    logic [2:0][31:0] t;
    logic [31:0]      corner;
  } lkv_mat_t;

  function automatic logic [31:0] lkv_sat32(input logic signed [63:0] x);
    logic [31:0] r;
    if (x > 64'sh0000_0000_7fff_ffff) begin
      r = 32'h7fff_ffff;
    end else if (x < -64'sh0000_0000_8000_0000) begin
      r = 32'h8000_0000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage

### rtl/core/lkv_norm.sv
// ----------------------------------------------------------------------------
// lkv_norm
// Pipelined 3-vector normalizer: align, sum of squares, root, three divides.
// ----------------------------------------------------------------------------
module lkv_norm
  import lkv_pkg::*;
#(
  parameter int FRAC  = LKV_FRAC_BITS,
  parameter int IN_W  = 33,
  parameter int TAG_W = 1
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic [2:0][IN_W-1:0]       in_v,
  input  logic [TAG_W-1:0]           in_tag,
  output logic                       out_valid,
  output logic [2:0][FRAC+1:0]       out_u,
  output logic                       out_zero,
  output logic [TAG_W-1:0]           out_tag
);

  localparam int XW  = (IN_W > LKV_ALIGN_W) ? IN_W : LKV_ALIGN_W;
  localparam int NSH = $clog2(XW);
  localparam int SW  = TAG_W + 4;
  localparam int NS  = LKV_SQRT_STEPS;
  localparam int QW  = FRAC + 1;
  localparam int NW  = LKV_ALIGN_W + FRAC + 1;
  localparam int MW  = LKV_ALIGN_W;

  logic [IN_W-1:0] mag [3];

  logic [XW-1:0]   am    [NSH+1][3];
  logic [SW-1:0]   aside [NSH+1];
  logic            av    [NSH+1];
  logic [NSH-1:0]  ztop;

  logic [MW-1:0]   bm [3];
  logic [2*MW-1:0] bsq [3];
  logic [SW-1:0]   bside;
  logic            bv;

  logic [63:0]     sn    [NS+1];
  logic [63:0]     sr    [NS+1];
  logic [MW-1:0]   cm    [NS+1][3];
  logic [SW-1:0]   cside [NS+1];
  logic            cv    [NS+1];
  logic [63:0]     tr    [NS];
  logic            sge   [NS];

  logic [NW-1:0]   nval [3];
  logic [QW-1:0]   dn    [QW+1][3];
  logic [31:0]     dr    [QW+1][3];
  logic [QW-1:0]   dq    [QW+1][3];
  logic [30:0]     dlen  [QW+1];
  logic [SW-1:0]   dside [QW+1];
  logic            dv    [QW+1];
  logic [31:0]     r2    [QW][3];
  logic            dge   [QW][3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag[i] = in_v[i][IN_W-1] ? (~in_v[i] + 1'b1) : in_v[i];
    end
    for (int j = 0; j < NSH; j++) begin
      ztop[j] = ((am[j][0] | am[j][1] | am[j][2]) >> (XW - (1 << (NSH - 1 - j)))) == '0;
    end
    for (int k = 0; k < NS; k++) begin
      tr[k]  = sr[k] + (64'(1) << (2 * (NS - 1 - k)));
      sge[k] = sn[k] >= tr[k];
    end
    for (int i = 0; i < 3; i++) begin
      nval[i] = NW'({cm[NS][i], {FRAC{1'b0}}}) + NW'(sr[NS][30:1]);
    end
    for (int j = 0; j < QW; j++) begin
      for (int i = 0; i < 3; i++) begin
        r2[j][i]  = {dr[j][i][30:0], dn[j][i][QW-1-j]};
        dge[j][i] = r2[j][i] >= {1'b0, dlen[j]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j <= NSH; j++) av[j] <= 1'b0;
      bv <= 1'b0;
      for (int k = 0; k <= NS; k++) cv[k] <= 1'b0;
      for (int j = 0; j <= QW; j++) dv[j] <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      av[0] <= in_valid;
      for (int j = 0; j < NSH; j++) av[j+1] <= av[j];
      bv    <= av[NSH];
      cv[0] <= bv;
      for (int k = 0; k < NS; k++) cv[k+1] <= cv[k];
      dv[0] <= cv[NS];
      for (int j = 0; j < QW; j++) dv[j+1] <= dv[j];
      out_valid <= dv[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // align: leading one of the largest magnitude to the top bit
      for (int i = 0; i < 3; i++) am[0][i] <= XW'(mag[i]);
      aside[0] <= {in_tag, in_v[2][IN_W-1], in_v[1][IN_W-1], in_v[0][IN_W-1],
                   (in_v[0] == '0) && (in_v[1] == '0) && (in_v[2] == '0)};
      for (int j = 0; j < NSH; j++) begin
        for (int i = 0; i < 3; i++) begin
          am[j+1][i] <= ztop[j] ? (am[j][i] << (1 << (NSH - 1 - j))) : am[j][i];
        end
        aside[j+1] <= aside[j];
      end
      // squares
      for (int i = 0; i < 3; i++) begin
        bm[i]  <= am[NSH][i][XW-1 -: MW];
        bsq[i] <= (2*MW)'(am[NSH][i][XW-1 -: MW]) * (2*MW)'(am[NSH][i][XW-1 -: MW]);
      end
      bside <= aside[NSH];
      // sum, then bitwise root
      sn[0] <= 64'(bsq[0]) + 64'(bsq[1]) + 64'(bsq[2]);
      sr[0] <= '0;
      for (int i = 0; i < 3; i++) cm[0][i] <= bm[i];
      cside[0] <= bside;
      for (int k = 0; k < NS; k++) begin
        sn[k+1] <= sge[k] ? (sn[k] - tr[k]) : sn[k];
        sr[k+1] <= sge[k] ? ((sr[k] >> 1) + (64'(1) << (2 * (NS - 1 - k)))) : (sr[k] >> 1);
        for (int i = 0; i < 3; i++) cm[k+1][i] <= cm[k][i];
        cside[k+1] <= cside[k];
      end
      // rounded quotients, one bit per stage
      for (int i = 0; i < 3; i++) begin
        dn[0][i] <= nval[i][QW-1:0];
        dr[0][i] <= 32'(nval[i] >> QW);
        dq[0][i] <= '0;
      end
      dlen[0]  <= sr[NS][30:0];
      dside[0] <= cside[NS];
      for (int j = 0; j < QW; j++) begin
        for (int i = 0; i < 3; i++) begin
          dn[j+1][i] <= dn[j][i];
          dr[j+1][i] <= dge[j][i] ? (r2[j][i] - {1'b0, dlen[j]}) : r2[j][i];
          dq[j+1][i] <= {dq[j][i][QW-2:0], dge[j][i]};
        end
        dlen[j+1]  <= dlen[j];
        dside[j+1] <= dside[j];
      end
      for (int i = 0; i < 3; i++) begin
        out_u[i] <= dside[QW][i+1] ? (~(FRAC+2)'(dq[QW][i]) + 1'b1) : (FRAC+2)'(dq[QW][i]);
      end
      out_zero <= dside[QW][0];
      out_tag  <= dside[QW][SW-1:4];
    end
  end

endmodule

### rtl/core/lkv_front.sv
// ----------------------------------------------------------------------------
// lkv_front
// Accepts eye/target/up transactions and computes the full view matrix.
// ----------------------------------------------------------------------------
module lkv_front
  import lkv_pkg::*;
#(
  parameter int FRAC = LKV_FRAC_BITS
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  logic [2:0][31:0] eye,
  input  logic [2:0][31:0] target,
  input  logic [2:0][31:0] up,
  output logic             res_valid,
  output lkv_mat_t         res
);

  localparam int FW   = FRAC + 2;
  localparam int CW   = FRAC + 34;
  localparam int VW   = 2 * FW + 1;
  localparam int DW   = FW + 32;
  localparam int SW2  = DW + 2;
  localparam int VRW  = FRAC + 3;
  localparam int VEW  = VRW + 32;
  localparam int VSW  = VEW + 2;
  localparam int HALF = 1 << (FRAC - 1);
  localparam int TGS  = 96 + 3 * FW + 1;

  // input stage
  logic             v0;
  logic [2:0][31:0] e0, u0;
  logic [2:0][32:0] d0;

  // forward normalize
  logic             nf_v, nf_z;
  logic [2:0][FW-1:0] nf_u;
  logic [191:0]     nf_tag;

  // cross product
  logic             c1v, c1z, c2v, c2z;
  logic [5:0][CW-1:0] c1p;
  logic [2:0][31:0] c1e, c2e;
  logic [2:0][FW-1:0] c1f, c2f;
  logic [2:0][CW-1:0] cc;

  // side normalize
  logic             ns_v, ns_z;
  logic [2:0][FW-1:0] ns_u;
  logic [TGS-1:0]   ns_tag;
  logic [2:0][31:0] ns_e;
  logic [2:0][FW-1:0] ns_f;

  // tail stages
  logic             t1v, t2v, t3v, t4v, t5v, t6v;
  logic             t1g, t2g, t3g, t4g, t5g, t6g;
  logic [5:0][VW-1:0] t1sf;
  logic [2:0][DW-1:0] t1se, t1fe;
  logic [2:0][FW-1:0] t1s, t1f, t2s, t2f, t3s, t3f, t4s, t4f, t5s, t5f, t6s, t6f;
  logic [2:0][31:0] t1e, t2e, t3e;
  logic [2:0][VW-1:0] t2vd;
  logic [SW2-1:0]   t2se, t2fe, t3se, t3fe, t4se, t4fe, t5se, t5fe, t6se, t6fe;
  logic [2:0][VRW-1:0] t3vv, t4vv, t5vv, t6vv;
  logic [2:0][VEW-1:0] t4ve;
  logic [VSW-1:0]   t5ve, t6ve;

  logic signed [VW-1:0]  vt [3];
  logic signed [SW2-1:0] set, fet;
  logic signed [VSW-1:0] vet;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      vt[i] = $signed(t2vd[i]) +
              (t2vd[i][VW-1] ? $signed(VW'(HALF - 1)) : $signed(VW'(HALF)));
    end
    set = $signed(t2se) + (t2se[SW2-1] ? $signed(SW2'(HALF - 1)) : $signed(SW2'(HALF)));
    fet = $signed(t2fe) + (t2fe[SW2-1] ? $signed(SW2'(HALF - 1)) : $signed(SW2'(HALF)));
    vet = $signed(t5ve) + (t5ve[VSW-1] ? $signed(VSW'(HALF - 1)) : $signed(VSW'(HALF)));
  end

  assign ns_e = ns_tag[95:0];
  assign ns_f = ns_tag[96 +: 3*FW];

  lkv_norm #(.FRAC(FRAC), .IN_W(33), .TAG_W(192)) u_norm_f (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v0),
    .in_v      (d0),
    .in_tag    ({u0, e0}),
    .out_valid (nf_v),
    .out_u     (nf_u),
    .out_zero  (nf_z),
    .out_tag   (nf_tag)
  );

  lkv_norm #(.FRAC(FRAC), .IN_W(CW), .TAG_W(TGS)) u_norm_s (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (c2v),
    .in_v      (cc),
    .in_tag    ({c2z, c2f, c2e}),
    .out_valid (ns_v),
    .out_u     (ns_u),
    .out_zero  (ns_z),
    .out_tag   (ns_tag)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      c1v <= 1'b0;
      c2v <= 1'b0;
      t1v <= 1'b0;
      t2v <= 1'b0;
      t3v <= 1'b0;
      t4v <= 1'b0;
      t5v <= 1'b0;
      t6v <= 1'b0;
      res_valid <= 1'b0;
    end else if (en) begin
      v0  <= in_valid;
      c1v <= nf_v;
      c2v <= c1v;
      t1v <= ns_v;
      t2v <= t1v;
      t3v <= t2v;
      t4v <= t3v;
      t5v <= t4v;
      t6v <= t5v;
      res_valid <= t6v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e0 <= eye;
      u0 <= up;
      for (int i = 0; i < 3; i++) begin
        d0[i] <= 33'($signed(target[i])) - 33'($signed(eye[i]));
      end

      // F x U, exact
      c1p[0] <= CW'($signed(nf_u[1])) * CW'($signed(nf_tag[96+64 +: 32]));
      c1p[1] <= CW'($signed(nf_u[2])) * CW'($signed(nf_tag[96+32 +: 32]));
      c1p[2] <= CW'($signed(nf_u[2])) * CW'($signed(nf_tag[96 +: 32]));
      c1p[3] <= CW'($signed(nf_u[0])) * CW'($signed(nf_tag[96+64 +: 32]));
      c1p[4] <= CW'($signed(nf_u[0])) * CW'($signed(nf_tag[96+32 +: 32]));
      c1p[5] <= CW'($signed(nf_u[1])) * CW'($signed(nf_tag[96 +: 32]));
      c1e <= nf_tag[95:0];
      c1f <= nf_u;
      c1z <= nf_z;

      cc[0] <= c1p[0] - c1p[1];
      cc[1] <= c1p[2] - c1p[3];
      cc[2] <= c1p[4] - c1p[5];
      c2e <= c1e;
      c2f <= c1f;
      c2z <= c1z;

      // S x F and dot products with the eye
      t1sf[0] <= VW'($signed(ns_u[1])) * VW'($signed(ns_f[2]));
      t1sf[1] <= VW'($signed(ns_u[2])) * VW'($signed(ns_f[1]));
      t1sf[2] <= VW'($signed(ns_u[2])) * VW'($signed(ns_f[0]));
      t1sf[3] <= VW'($signed(ns_u[0])) * VW'($signed(ns_f[2]));
      t1sf[4] <= VW'($signed(ns_u[0])) * VW'($signed(ns_f[1]));
      t1sf[5] <= VW'($signed(ns_u[1])) * VW'($signed(ns_f[0]));
      for (int i = 0; i < 3; i++) begin
        t1se[i] <= DW'($signed(ns_u[i])) * DW'($signed(ns_e[i]));
        t1fe[i] <= DW'($signed(ns_f[i])) * DW'($signed(ns_e[i]));
      end
      t1s <= ns_u;
      t1f <= ns_f;
      t1e <= ns_e;
      t1g <= ns_z | ns_tag[TGS-1];

      t2vd[0] <= t1sf[0] - t1sf[1];
      t2vd[1] <= t1sf[2] - t1sf[3];
      t2vd[2] <= t1sf[4] - t1sf[5];
      t2se <= SW2'($signed(t1se[0])) + SW2'($signed(t1se[1])) + SW2'($signed(t1se[2]));
      t2fe <= SW2'($signed(t1fe[0])) + SW2'($signed(t1fe[1])) + SW2'($signed(t1fe[2]));
      t2s <= t1s;
      t2f <= t1f;
      t2e <= t1e;
      t2g <= t1g;

      for (int i = 0; i < 3; i++) t3vv[i] <= VRW'(vt[i] >>> FRAC);
      t3se <= SW2'(set >>> FRAC);
      t3fe <= SW2'(fet >>> FRAC);
      t3s <= t2s;
      t3f <= t2f;
      t3e <= t2e;
      t3g <= t2g;

      for (int i = 0; i < 3; i++) begin
        t4ve[i] <= VEW'($signed(t3vv[i])) * VEW'($signed(t3e[i]));
      end
      t4vv <= t3vv;
      t4se <= t3se;
      t4fe <= t3fe;
      t4s <= t3s;
      t4f <= t3f;
      t4g <= t3g;

      t5ve <= VSW'($signed(t4ve[0])) + VSW'($signed(t4ve[1])) + VSW'($signed(t4ve[2]));
      t5vv <= t4vv;
      t5se <= t4se;
      t5fe <= t4fe;
      t5s <= t4s;
      t5f <= t4f;
      t5g <= t4g;

      t6ve <= VSW'(vet >>> FRAC);
      t6vv <= t5vv;
      t6se <= t5se;
      t6fe <= t5fe;
      t6s <= t5s;
      t6f <= t5f;
      t6g <= t5g;

      res.degen <= t6g;
      for (int i = 0; i < 3; i++) begin
        res.s[i]  <= t6g ? '0 : 32'($signed(t6s[i]));
        res.v[i]  <= t6g ? '0 : 32'($signed(t6vv[i]));
        res.nf[i] <= t6g ? '0 : (~32'($signed(t6f[i])) + 1'b1);
      end
      res.t[0]   <= t6g ? '0 : lkv_sat32(-64'($signed(t6se)));
      res.t[1]   <= t6g ? '0 : lkv_sat32(-64'($signed(t6ve)));
      res.t[2]   <= t6g ? '0 : lkv_sat32(64'($signed(t6fe)));
      res.corner <= t6g ? '0 : (32'(1) << FRAC);
    end
  end

endmodule

### rtl/core/lkv_queue.sv
// ----------------------------------------------------------------------------
// lkv_queue
// Short queue of finished matrices between the front and the column emitter.
// ----------------------------------------------------------------------------
module lkv_queue
  import lkv_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  lkv_mat_t wdata,
  input  logic     pop,
  output lkv_mat_t rdata,
  output logic     full,
  output logic     empty
);

  localparam int PW = (LKV_QDEPTH > 1) ? $clog2(LKV_QDEPTH) : 1;
  localparam int NW = $clog2(LKV_QDEPTH + 1);

  lkv_mat_t        mem [LKV_QDEPTH];
  logic [PW-1:0]   wptr, rptr;
  logic [NW-1:0]   count;

  assign full  = count == NW'(LKV_QDEPTH);
  assign empty = count == '0;
  assign rdata = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PW'(LKV_QDEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == PW'(LKV_QDEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= wdata;
    end
  end

endmodule

### rtl/core/lkv_back.sv
// ----------------------------------------------------------------------------
// lkv_back
// Emits the queued matrix as four column transactions through an output register.
// ----------------------------------------------------------------------------
module lkv_back
  import lkv_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  lkv_mat_t    head,
  input  logic        empty,
  output logic        pop,
  input  logic        stall,
  output logic        valid,
  output logic [1:0]  col_index,
  output logic [31:0] entry_row0,
  output logic [31:0] entry_row1,
  output logic [31:0] entry_row2,
  output logic [31:0] entry_row3,
  output logic        last_col,
  output logic        degenerate
);

  logic       load;
  logic [1:0] cnt;

  assign load = !valid || !stall;
  assign pop  = load && !empty && (cnt == LKV_COL_LAST);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      cnt   <= '0;
    end else if (load) begin
      valid <= !empty;
      if (!empty) begin
        cnt <= cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && !empty) begin
      col_index  <= cnt;
      last_col   <= cnt == LKV_COL_LAST;
      degenerate <= head.degen;
      if (cnt == LKV_COL_LAST) begin
        entry_row0 <= head.t[0];
        entry_row1 <= head.t[1];
        entry_row2 <= head.t[2];
        entry_row3 <= head.corner;
      end else begin
        entry_row0 <= head.s[cnt];
        entry_row1 <= head.v[cnt];
        entry_row2 <= head.nf[cnt];
        entry_row3 <= '0;
      end
    end
  end

  a_last_flag: assert property (@(posedge clk) disable iff (rst)
    valid |-> (last_col == (col_index == LKV_COL_LAST)))
    else $error("last_col out of step with col_index");

  a_col_next: assert property (@(posedge clk) disable iff (rst)
    valid && !stall && !last_col |=> valid && (col_index == 2'($past(col_index) + 2'd1)))
    else $error("column sequence broken inside a matrix");

  a_degen_hold: assert property (@(posedge clk) disable iff (rst)
    valid && !stall && !last_col |=> degenerate == $past(degenerate))
    else $error("degenerate flag changed inside a matrix");

  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    valid && degenerate |-> entry_row0 == '0 && entry_row1 == '0 &&
                            entry_row2 == '0 && entry_row3 == '0)
    else $error("degenerate matrix with nonzero entry");

endmodule

### rtl/core/lookat_view_matrix.sv
// ----------------------------------------------------------------------------
// lookat_view_matrix
// Look-at view matrix generator, fixed point, column-major output.
// ----------------------------------------------------------------------------
// One transaction of eye, target and up enters per cycle, unless in_stall is
// high, into a fully pipelined datapath (two normalizers, each a bitwise
// square root and bit-per-stage dividers).
// Each input yields four column transactions through the single output port,
// which limits the sustained input rate; a two-entry matrix
// queue sits between the pipeline and the column emitter.
module lookat_view_matrix
  import lkv_pkg::*;
#(
  parameter int FRAC_BITS = LKV_FRAC_BITS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] eye_x,
  input  logic signed [31:0] eye_y,
  input  logic signed [31:0] eye_z,
  input  logic signed [31:0] target_x,
  input  logic signed [31:0] target_y,
  input  logic signed [31:0] target_z,
  input  logic signed [31:0] up_x,
  input  logic signed [31:0] up_y,
  input  logic signed [31:0] up_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         col_index,
  output logic signed [31:0] entry_row0,
  output logic signed [31:0] entry_row1,
  output logic signed [31:0] entry_row2,
  output logic signed [31:0] entry_row3,
  output logic               last_col,
  output logic               degenerate
);

  logic     en, fr_valid, q_full, q_empty, q_pop, q_push;
  lkv_mat_t fr_mat, q_head;

  assign en       = !fr_valid || !q_full;
  assign q_push   = fr_valid && !q_full;
  assign in_stall = !en;

  lkv_front #(.FRAC(FRAC_BITS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (in_valid),
    .eye       ({eye_z, eye_y, eye_x}),
    .target    ({target_z, target_y, target_x}),
    .up        ({up_z, up_y, up_x}),
    .res_valid (fr_valid),
    .res       (fr_mat)
  );

  lkv_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (fr_mat),
    .pop   (q_pop),
    .rdata (q_head),
    .full  (q_full),
    .empty (q_empty)
  );

  lkv_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (q_head),
    .empty      (q_empty),
    .pop        (q_pop),
    .stall      (out_stall),
    .valid      (out_valid),
    .col_index  (col_index),
    .entry_row0 (entry_row0),
    .entry_row1 (entry_row1),
    .entry_row2 (entry_row2),
    .entry_row3 (entry_row3),
    .last_col   (last_col),
    .degenerate (degenerate)
  );

endmodule

### tb/lookat_view_matrix_test.sv
// ----------------------------------------------------------------------------
// lookat_view_matrix_test
// Self-checking bench: drives eye/target/up transactions with random idling,
// predicts the four view matrix columns of each, and compares them in order.
// ----------------------------------------------------------------------------
module lookat_view_matrix_test;
  import lkv_pkg::*;

  localparam int FB = LKV_FRAC_BITS;
  localparam int LIMIT = 400000;

  typedef struct {
    logic signed [31:0] f [9];
  } view_in_t;

  typedef struct {
    logic [1:0]         col;
    logic signed [31:0] r [4];
    logic               last;
    logic               degen;
  } column_t;

  logic clk, rst;
  logic in_valid, in_stall, out_valid, out_stall;
  logic signed [31:0] eye_x, eye_y, eye_z, target_x, target_y, target_z;
  logic signed [31:0] up_x, up_y, up_z;
  logic [1:0] col_index;
  logic signed [31:0] entry_row0, entry_row1, entry_row2, entry_row3;
  logic last_col, degenerate;

  view_in_t pending_views[$];
  column_t  expected_columns[$];
  int errors = 0;
  int cycle_count = 0;
  bit idle_on = 1;
  bit hold_send = 0;
  bit in_taken = 0;
  int send_gap = 0, recv_gap = 0;

  lookat_view_matrix DUT (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic logic [63:0] mag(input logic signed [63:0] x);
    return x < 0 ? -x : x;
  endfunction

  function automatic logic signed [63:0] round_frac(input logic signed [63:0] x);
    logic [63:0] m;
    m = (mag(x) + (64'd1 << (FB - 1))) >> FB;
    return x < 0 ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic [63:0] int_sqrt(input logic [63:0] n);
    logic [63:0] res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic bit unit_vec(input logic signed [63:0] v [3],
                                  output logic signed [63:0] u [3]);
    logic [63:0] m [3];
    logic [63:0] mx, sum, len, q;
    mx = 0;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = mag(v[i]);
      if (m[i] > mx) mx = m[i];
      u[i] = 0;
    end
    if (mx == 0) return 0;
    while (mx >= (64'd1 << 30)) begin
      mx >>= 1;
      for (int i = 0; i < 3; i++) m[i] >>= 1;
    end
    while (mx < (64'd1 << 29)) begin
      mx <<= 1;
      for (int i = 0; i < 3; i++) m[i] <<= 1;
    end
    for (int i = 0; i < 3; i++) sum += m[i] * m[i];
    len = int_sqrt(sum);
    for (int i = 0; i < 3; i++) begin
      q = ((m[i] << FB) + (len >> 1)) / len;
      u[i] = v[i] < 0 ? -$signed(q) : $signed(q);
    end
    return 1;
  endfunction

  function automatic logic signed [31:0] sat(input logic signed [63:0] x);
    if (x > 64'sd2147483647) return 32'sh7fffffff;
    if (x < -64'sd2147483648) return 32'sh80000000;
    return x[31:0];
  endfunction

  task automatic predict_view_matrix(input view_in_t t);
    logic signed [63:0] e [3], d [3], up [3], f [3], c [3], s [3], v [3];
    logic signed [31:0] mat [16];
    bit degen;
    column_t col;
    for (int i = 0; i < 3; i++) begin
      e[i] = 64'(t.f[i]);
      d[i] = 64'(t.f[3 + i]) - e[i];
      up[i] = 64'(t.f[6 + i]);
    end
    degen = !unit_vec(d, f);
    if (!degen) begin
      c[0] = f[1] * up[2] - f[2] * up[1];
      c[1] = f[2] * up[0] - f[0] * up[2];
      c[2] = f[0] * up[1] - f[1] * up[0];
      degen = !unit_vec(c, s);
    end
    for (int i = 0; i < 16; i++) mat[i] = 0;
    if (!degen) begin
      v[0] = round_frac(s[1] * f[2] - s[2] * f[1]);
      v[1] = round_frac(s[2] * f[0] - s[0] * f[2]);
      v[2] = round_frac(s[0] * f[1] - s[1] * f[0]);
      for (int i = 0; i < 3; i++) begin
        mat[4 * i] = 32'(s[i]);
        mat[4 * i + 1] = 32'(v[i]);
        mat[4 * i + 2] = 32'(-f[i]);
      end
      mat[12] = sat(-round_frac(s[0] * e[0] + s[1] * e[1] + s[2] * e[2]));
      mat[13] = sat(-round_frac(v[0] * e[0] + v[1] * e[1] + v[2] * e[2]));
      mat[14] = sat(round_frac(f[0] * e[0] + f[1] * e[1] + f[2] * e[2]));
      mat[15] = 32'sd1 << FB;
    end
    for (int k = 0; k < 4; k++) begin
      col.col = 2'(k);
      for (int i = 0; i < 4; i++) col.r[i] = mat[4 * k + i];
      col.last = (k == 3);
      col.degen = degen;
      expected_columns.push_back(col);
    end
  endtask

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %h expected %h", what, got, want);
    errors++;
  endtask

  task automatic add(input logic signed [31:0] a [9]);
    view_in_t t;
    t.f = a;
    pending_views.push_back(t);
  endtask

  function automatic logic signed [31:0] rnd_coord(input int mode);
    case (mode)
      0: return $urandom;
      1: return $signed($urandom_range(0, 32'h000fffff)) - 32'sh00080000;
      default: return $signed($urandom_range(0, 32'h3ff)) - 32'sh200;
    endcase
  endfunction

  // driver
  always @(negedge clk) begin
    view_in_t t;
    if (rst) begin
      in_valid <= 0;
    end else if (!in_valid || in_taken) begin
      if (in_valid) void'(pending_views.pop_front());
      if (idle_on && send_gap == 0 && $urandom_range(0, 15) == 0)
        send_gap = $urandom_range(1, 18);
      if (send_gap > 0) send_gap--;
      if (pending_views.size() > 0 && send_gap == 0 && !hold_send) begin
        t = pending_views[0];
        in_valid <= 1;
        {eye_x, eye_y, eye_z} <= {t.f[0], t.f[1], t.f[2]};
        {target_x, target_y, target_z} <= {t.f[3], t.f[4], t.f[5]};
        {up_x, up_y, up_z} <= {t.f[6], t.f[7], t.f[8]};
      end else begin
        in_valid <= 0;
      end
    end
    if (idle_on && recv_gap == 0 && $urandom_range(0, 15) == 0)
      recv_gap = $urandom_range(1, 18);
    if (recv_gap > 0) recv_gap--;
    out_stall <= (recv_gap > 0);
  end

  // input acceptance and output monitor
  always @(posedge clk) begin
    view_in_t t;
    column_t w;
    cycle_count++;
    in_taken = !rst && in_valid && !in_stall;
    if (in_taken) begin
      t.f = '{eye_x, eye_y, eye_z, target_x, target_y, target_z, up_x, up_y, up_z};
      predict_view_matrix(t);
    end
    if (!rst && out_valid && !out_stall) begin
      if (expected_columns.size() == 0) begin
        report("unexpected transaction", 32'(col_index), 32'd0);
      end else begin
        w = expected_columns.pop_front();
        if (col_index !== w.col) report("col_index", 32'(col_index), 32'(w.col));
        if (entry_row0 !== w.r[0]) report("entry_row0", entry_row0, w.r[0]);
        if (entry_row1 !== w.r[1]) report("entry_row1", entry_row1, w.r[1]);
        if (entry_row2 !== w.r[2]) report("entry_row2", entry_row2, w.r[2]);
        if (entry_row3 !== w.r[3]) report("entry_row3", entry_row3, w.r[3]);
        if (last_col !== w.last) report("last_col", 32'(last_col), 32'(w.last));
        if (degenerate !== w.degen) report("degenerate", 32'(degenerate), 32'(w.degen));
      end
    end
    if (cycle_count > LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    logic signed [31:0] a [9];
    int mode;
    rst = 1;
    in_valid = 0;
    out_stall = 0;
    {eye_x, eye_y, eye_z, target_x, target_y, target_z, up_x, up_y, up_z} = '0;
    repeat (11) @(posedge clk);
    rst <= 0;
    // directed
    add('{0, 0, 0, 0, 0, -65536, 0, 65536, 0});
    add('{65536, 131072, 196608, 65536, 131072, 196608, 0, 65536, 0});   // eye == target
    add('{0, 0, 0, 0, 0, -65536, 0, 0, -65536});                         // up parallel
    add('{0, 0, 0, 0, 0, -65536, 0, 0, 0});                              // up zero
    add('{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
          32'sh80000000, 32'sh80000000, 32'sh80000001, 0, 65536, 0});
    add('{32'sh80000000, 32'sh80000000, 32'sh80000000,
          32'sh7fffffff, 32'sh7fffffff, 32'sh7ffffffe, 32'sh80000000, 32'sh7fffffff, 1});
    add('{32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 0, 0, 0, 1, -1, 32'sh7fffffff});
    add('{32'sh70000000, 32'sh70000000, 32'sh70000000, 32'sh90000000, 0, 0, 0, 65536, 0});
    add('{1, 0, 0, 0, 0, 0, 0, 1, 0});
    add('{-1, -1, -1, 0, 0, 0, 32'shffffffff, 32'sh7fffffff, 0});
    add('{32'sh55555555, 32'shaaaaaaaa, 32'sh12345678, 32'shedcba987, 32'sh0f0f0f0f,
          32'shf0f0f0f0, 32'sh33333333, 32'shcccccccc, 32'sh5a5a5a5a});
    for (int i = 0; i < 420; i++) begin
      mode = $urandom_range(0, 2);
      for (int j = 0; j < 9; j++) a[j] = rnd_coord(mode);
      if ($urandom_range(0, 19) == 0) for (int j = 0; j < 3; j++) a[3 + j] = a[j];
      if ($urandom_range(0, 19) == 0) for (int j = 0; j < 3; j++) a[6 + j] = a[3 + j] - a[j];
      add(a);
      if (i == 150) begin
        wait (pending_views.size() == 0 && !in_valid);
        hold_send = 1;
        wait (expected_columns.size() == 0);
        @(posedge clk);
        hold_send = 0;
      end
      if (i == 350) begin
        wait (pending_views.size() < 5);
        idle_on = 0;
      end
    end
    idle_on = 0;
    wait (pending_views.size() == 0 && !in_valid);
    wait (expected_columns.size() == 0);
    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
